// ----- rtl/fri_pkg.sv -----
// Shared types, codes and constants for the FASTA record indexer.
`default_nettype none

package fri_pkg;

  // Default sizing
  localparam int unsigned MAX_RECORDS_DEF   = 1024;
  localparam int unsigned POSITION_BITS_DEF = 32;

  // Fixed field widths of the item ports
  localparam int unsigned REC_W    = 10;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned IN_POS_W = 32;

  // Result queue sizing
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  // Characters the parser reacts to
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef enum logic [1:0] {
    MODE_BYTE   = 2'd0,
    MODE_EOF    = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_SEQUENCE = 3'd1,
    KIND_START    = 3'd2,
    KIND_HIT      = 3'd3,
    KIND_MISS     = 3'd4,
    KIND_ERROR    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    PS_NEWLINE  = 2'd0,
    PS_HEADER   = 2'd1,
    PS_SEQUENCE = 2'd2,
    PS_COMMENT  = 2'd3
  } pstate_e;

  typedef enum logic {
    CT_IDLE   = 1'b0,
    CT_SEARCH = 1'b1
  } ctrl_e;

  typedef enum logic [1:0] {
    SR_IDLE  = 2'd0,
    SR_ISSUE = 2'd1,
    SR_WAIT  = 2'd2,
    SR_DONE  = 2'd3
  } search_e;

  typedef struct packed {
    logic [1:0]          mode;
    logic [7:0]          in_byte;
    logic [IN_POS_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       out_byte;
    logic [REC_W-1:0] record_index;
    logic [OUT_W-1:0] store_position;
    logic [OUT_W-1:0] local_offset;
    logic             last;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/fri_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fri_ram import fri_pkg::*; #(
  parameter int unsigned WIDTH = POSITION_BITS_DEF,
  parameter int unsigned DEPTH = MAX_RECORDS_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/fri_queue.sv -----
// Small result queue: takes up to two items a cycle, hands out one while the output is not stalled.
`default_nettype none

module fri_queue import fri_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_a_i,
  input  logic      push_b_i,
  input  out_item_t item_a_i,
  input  out_item_t item_b_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  out_item_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = slot_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  // Room for a full pair of results
  assign room_o      = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q + QPTR_W'(push_a_i) + QPTR_W'(push_b_i);
    rd_d  = rd_q + QPTR_W'(pop);
    cnt_d = cnt_q + QCNT_W'(push_a_i) + QCNT_W'(push_b_i) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed items in the free slots
  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      slot_q[wr_q] <= item_a_i;
    end
    if (push_b_i) begin
      slot_q[QPTR_W'(wr_q + 1'b1)] <= item_b_i;
    end
  end

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_b_i |-> push_a_i)
    else $error("second result pushed without first");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

// ----- rtl/fri_search.sv -----
// Binary search over the sequence-end memory; each probe is a registered read followed by a compare.
`default_nettype none

module fri_search import fri_pkg::*; #(
  parameter int unsigned MAX_RECORDS   = MAX_RECORDS_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  localparam int unsigned AW   = $clog2(MAX_RECORDS),
  localparam int unsigned CW   = AW + 1,
  localparam int unsigned PW   = POSITION_BITS,
  localparam int unsigned CMPW = (PW > IN_POS_W) ? PW : IN_POS_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [IN_POS_W-1:0] pos_i,
  input  logic [CW-1:0]       count_i,
  input  logic [PW-1:0]       last_end_i,
  output logic                rd_en_o,
  output logic [AW-1:0]       rd_addr_o,
  input  logic [PW-1:0]       rd_data_i,
  output logic                done_o,
  output out_item_t           result_o
);

  search_e             st_q, st_d;
  logic [CW-1:0]       lo_q, hi_q, mid;
  logic [AW-1:0]       mid_q;
  logic [PW-1:0]       prev_q, probe;
  logic [IN_POS_W-1:0] pos_q;
  logic                hit_q, miss;

  // Miss when the table is empty or the position is past the last end
  assign miss  = (count_i == '0) || (CMPW'(pos_i) >= CMPW'(last_end_i));
  assign mid   = lo_q + ((hi_q - lo_q) >> 1);
  // The open record's end lives in the fill register, not in memory
  assign probe = (mid_q == AW'(count_i - 1'b1)) ? last_end_i : rd_data_i;

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SR_IDLE:  if (start_i) st_d = miss ? SR_DONE : SR_ISSUE;
      SR_ISSUE: st_d = (lo_q < hi_q) ? SR_WAIT : SR_DONE;
      SR_WAIT:  st_d = SR_ISSUE;
      SR_DONE:  st_d = SR_IDLE;
      default:  st_d = SR_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rd_en_o   = (st_q == SR_ISSUE) && (lo_q < hi_q);
    rd_addr_o = mid[AW-1:0];
    done_o    = (st_q == SR_DONE);
    result_o  = '0;
    result_o.last = 1'b1;
    if (hit_q) begin
      result_o.kind         = KIND_HIT;
      result_o.record_index = REC_W'(lo_q);
      result_o.local_offset = OUT_W'(PW'(CMPW'(pos_q) - CMPW'(prev_q)));
    end else begin
      result_o.kind = KIND_MISS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SR_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Narrow the interval after each probe
  always_ff @(posedge clk_i) begin
    if (st_q == SR_IDLE && start_i) begin
      pos_q  <= pos_i;
      lo_q   <= '0;
      hi_q   <= count_i;
      prev_q <= '0;
      hit_q  <= !miss;
    end
    if (rd_en_o) begin
      mid_q <= mid[AW-1:0];
    end
    if (st_q == SR_WAIT) begin
      if (CMPW'(pos_q) < CMPW'(probe)) begin
        hi_q <= CW'(mid_q);
      end else begin
        lo_q   <= CW'(mid_q) + 1'b1;
        prev_q <= probe;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (st_q == SR_IDLE))
    else $error("search started while busy");

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SR_ISSUE) |-> (lo_q <= hi_q) && (hi_q <= count_i))
    else $error("search interval out of range");

  a_hit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_q) |-> (lo_q < count_i))
    else $error("hit beyond record count");

endmodule

`default_nettype wire

// ----- rtl/fri_parser.sv -----
// FASTA byte parser: record state, fill counters and the sequence-end writes.
`default_nettype none

module fri_parser import fri_pkg::*; #(
  parameter int unsigned MAX_RECORDS   = MAX_RECORDS_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  localparam int unsigned AW = $clog2(MAX_RECORDS),
  localparam int unsigned CW = AW + 1,
  localparam int unsigned PW = POSITION_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  in_item_t      in_item_i,
  input  logic          room_i,
  output logic          search_start_o,
  output logic [CW-1:0] count_o,
  output logic [PW-1:0] last_end_o,
  input  logic          search_done_i,
  input  out_item_t     search_result_i,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [PW-1:0] mem_wdata_o,
  output logic          push_a_o,
  output logic          push_b_o,
  output out_item_t     item_a_o,
  output out_item_t     item_b_o
);

  ctrl_e         ctrl_q, ctrl_d;
  pstate_e       pstate_q, pstate_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] hfill_q, hfill_d, sfill_q, sfill_d;
  logic          failed_q, failed_d;
  logic          accept, has_rec, printable, va, vb;
  logic [7:0]    b;
  logic [REC_W-1:0] rec_cur;
  out_item_t     ra, rb;

  function automatic out_item_t mk(input kind_e k, input logic [7:0] v,
                                   input logic [REC_W-1:0] r,
                                   input logic [OUT_W-1:0] s);
    out_item_t t;
    t.kind           = k;
    t.out_byte       = v;
    t.record_index   = r;
    t.store_position = s;
    t.local_offset   = '0;
    t.last           = 1'b0;
    return t;
  endfunction

  assign accept    = in_valid_i && !in_stall_o;
  assign b         = in_item_i.in_byte;
  assign has_rec   = (count_q != '0);
  assign rec_cur   = REC_W'(count_q - 1'b1);
  assign printable = (b >= CH_SPACE) && (b <= CH_DEL);
  assign count_o    = count_q;
  assign last_end_o = sfill_q;
  assign search_start_o = accept && (in_item_i.mode == MODE_LOOKUP);

  // Control next state
  always_comb begin
    ctrl_d = ctrl_q;
    unique case (ctrl_q)
      CT_IDLE:   if (search_start_o) ctrl_d = CT_SEARCH;
      CT_SEARCH: if (search_done_i) ctrl_d = CT_IDLE;
      default:   ctrl_d = CT_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o = !((ctrl_q == CT_IDLE) && room_i);
  end

  // Parse one item and form its results
  always_comb begin
    pstate_d    = pstate_q;
    count_d     = count_q;
    hfill_d     = hfill_q;
    sfill_d     = sfill_q;
    failed_d    = failed_q;
    va          = 1'b0;
    vb          = 1'b0;
    ra          = '0;
    rb          = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(count_q - 1'b1);
    mem_wdata_o = sfill_q + 1'b1;
    if (accept) begin
      case (in_item_i.mode) inside
        MODE_BYTE, MODE_EOF: begin
          if (failed_q) begin
            va = 1'b1;
            ra = mk(KIND_ERROR, CH_NUL, '0, '0);
          end else if (in_item_i.mode == MODE_EOF) begin
            pstate_d = PS_NEWLINE;
            if (has_rec) begin
              va      = 1'b1;
              ra      = mk(KIND_SEQUENCE, CH_NUL, rec_cur, OUT_W'(sfill_q));
              sfill_d = sfill_q + 1'b1;
            end
          end else begin
            unique case (pstate_q)
              PS_COMMENT: begin
                if (b == CH_NL) pstate_d = PS_NEWLINE;
              end
              PS_NEWLINE: begin
                if (b == CH_GT) begin
                  if (count_q == CW'(MAX_RECORDS)) begin
                    failed_d = 1'b1;
                    va       = 1'b1;
                    ra       = mk(KIND_ERROR, CH_NUL, '0, '0);
                  end else begin
                    pstate_d = PS_HEADER;
                    count_d  = count_q + 1'b1;
                    if (has_rec) begin
                      // Close the previous sequence and commit its end
                      va       = 1'b1;
                      ra       = mk(KIND_SEQUENCE, CH_NUL, rec_cur, OUT_W'(sfill_q));
                      sfill_d  = sfill_q + 1'b1;
                      mem_we_o = 1'b1;
                      vb       = 1'b1;
                      rb       = mk(KIND_START, CH_NUL, REC_W'(count_q), OUT_W'(hfill_q));
                    end else begin
                      va = 1'b1;
                      ra = mk(KIND_START, CH_NUL, REC_W'(count_q), OUT_W'(hfill_q));
                    end
                  end
                end else if (b == CH_SEMI) begin
                  pstate_d = PS_COMMENT;
                end else if (printable) begin
                  pstate_d = PS_SEQUENCE;
                  if (has_rec) begin
                    va      = 1'b1;
                    ra      = mk(KIND_SEQUENCE, b, rec_cur, OUT_W'(sfill_q));
                    sfill_d = sfill_q + 1'b1;
                  end
                end
              end
              PS_HEADER: begin
                if (b == CH_SEMI || b == CH_NL) begin
                  pstate_d = (b == CH_SEMI) ? PS_COMMENT : PS_NEWLINE;
                  if (has_rec) begin
                    va      = 1'b1;
                    ra      = mk(KIND_HEADER, CH_NUL, rec_cur, OUT_W'(hfill_q));
                    hfill_d = hfill_q + 1'b1;
                  end
                end else if (printable || b == CH_TAB) begin
                  if (has_rec) begin
                    va      = 1'b1;
                    ra      = mk(KIND_HEADER, b, rec_cur, OUT_W'(hfill_q));
                    hfill_d = hfill_q + 1'b1;
                  end
                end
              end
              default: begin
                if (b == CH_SEMI) begin
                  pstate_d = PS_COMMENT;
                end else if (b == CH_NL) begin
                  pstate_d = PS_NEWLINE;
                end else if (printable && has_rec) begin
                  va      = 1'b1;
                  ra      = mk(KIND_SEQUENCE, b, rec_cur, OUT_W'(sfill_q));
                  sfill_d = sfill_q + 1'b1;
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
    // Mark the final result of the item
    if (vb) begin
      rb.last = 1'b1;
    end else if (va) begin
      ra.last = 1'b1;
    end
  end

  // Hand results to the queue; a finished lookup uses the first lane
  always_comb begin
    push_a_o = va || search_done_i;
    push_b_o = vb;
    item_a_o = search_done_i ? search_result_i : ra;
    item_b_o = rb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q   <= CT_IDLE;
      pstate_q <= PS_NEWLINE;
      count_q  <= '0;
      hfill_q  <= '0;
      sfill_q  <= '0;
      failed_q <= 1'b0;
    end else begin
      ctrl_q   <= ctrl_d;
      pstate_q <= pstate_d;
      count_q  <= count_d;
      hfill_q  <= hfill_d;
      sfill_q  <= sfill_d;
      failed_q <= failed_d;
    end
  end

  a_lookup_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.mode == MODE_LOOKUP) |=> in_stall_o)
    else $error("input taken during lookup");

  a_write_has_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (count_q != '0) && (count_q < CW'(MAX_RECORDS)))
    else $error("sequence end written without open record");

  a_failed_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && failed_q && (in_item_i.mode == MODE_BYTE || in_item_i.mode == MODE_EOF))
      |-> (push_a_o && !push_b_o && !mem_we_o && count_d == count_q))
    else $error("failed block changed state");

endmodule

`default_nettype wire

// ----- rtl/fasta_record_indexer.sv -----
// Top level of the FASTA record indexer: parser, sequence-end memory, search, result queue.
`default_nettype none

// File bytes and end-of-file items are taken one per cycle while no lookup is
// in progress and the result queue has room for two results; each gives zero,
// one or two results. A taken lookup stalls the input until its search is done:
// a miss needs no probe, and a hit needs p <= ceil(log2(records+1)) probes
// of the sequence-end memory, each a registered read followed by a compare.
// Each record's sequence end is committed to memory when the next record opens;
// the open record's end is the sequence fill counter itself, so no entry is
// read before it is written and no clearing pass runs after reset. A result
// queue of four items sits between the parser and the output, so input
// continues while results wait.

module fasta_record_indexer import fri_pkg::*; #(
  parameter int unsigned MAX_RECORDS   = MAX_RECORDS_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned PW = POSITION_BITS;

  logic          room, search_start, search_done;
  logic [CW-1:0] count;
  logic [PW-1:0] last_end, mem_wdata, mem_rdata;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic          push_a, push_b;
  out_item_t     item_a, item_b, search_result;

  fri_parser #(
    .MAX_RECORDS  (MAX_RECORDS),
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_item_i      (in_item_i),
    .room_i         (room),
    .search_start_o (search_start),
    .count_o        (count),
    .last_end_o     (last_end),
    .search_done_i  (search_done),
    .search_result_i(search_result),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .push_a_o       (push_a),
    .push_b_o       (push_b),
    .item_a_o       (item_a),
    .item_b_o       (item_b)
  );

  fri_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_RECORDS)
  ) u_ends (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  fri_search #(
    .MAX_RECORDS  (MAX_RECORDS),
    .POSITION_BITS(POSITION_BITS)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (search_start),
    .pos_i     (in_item_i.position),
    .count_i   (count),
    .last_end_i(last_end),
    .rd_en_o   (mem_re),
    .rd_addr_o (mem_raddr),
    .rd_data_i (mem_rdata),
    .done_o    (search_done),
    .result_o  (search_result)
  );

  fri_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_a_i   (push_a),
    .push_b_i   (push_b),
    .item_a_i   (item_a),
    .item_b_i   (item_b),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/fasta_record_indexer_tb.sv -----
// Self-checking testbench for the FASTA record indexer: parse, index and lookup traffic.
`default_nettype none

module fasta_record_indexer_tb import fri_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Tracks parser and index state and holds the results still owed by the block
  class fasta_index_board;
    pstate_e     pstate;
    logic [10:0] rec_count;
    logic [31:0] hdr_fill;
    logic [31:0] seq_fill;
    logic [31:0] seq_ends [MAX_RECORDS_DEF];
    bit          failed;
    out_item_t   owed [$];
    out_item_t   fresh [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      pstate    = PS_NEWLINE;
      rec_count = '0;
      hdr_fill  = '0;
      seq_fill  = '0;
      failed    = 1'b0;
      errors    = 0;
      checked   = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void emit(kind_e k, logic [7:0] b, logic [10:0] rec, logic [31:0] at,
                       logic [31:0] offset);
      out_item_t r;
      r.kind           = k;
      r.out_byte       = b;
      r.record_index   = rec[REC_W-1:0];
      r.store_position = at;
      r.local_offset   = offset;
      r.last           = 1'b0;
      fresh.push_back(r);
    endfunction

    // Append to the open record's sequence and move its end along
    function void seq_byte(logic [7:0] b);
      logic [31:0] at;
      at = seq_fill;
      if (rec_count == 0) return;
      seq_fill = seq_fill + 1;
      seq_ends[rec_count - 11'd1] = seq_fill;
      emit(KIND_SEQUENCE, b, rec_count - 11'd1, at, '0);
    endfunction

    function void head_byte(logic [7:0] b);
      logic [31:0] at;
      at = hdr_fill;
      if (rec_count == 0) return;
      hdr_fill = hdr_fill + 1;
      emit(KIND_HEADER, b, rec_count - 11'd1, at, '0);
    endfunction

    function void parse_byte(logic [7:0] b);
      bit printable;
      printable = (b >= CH_SPACE) && (b <= CH_DEL);
      case (pstate)
        PS_COMMENT: begin
          if (b == CH_NL) pstate = PS_NEWLINE;
        end
        PS_NEWLINE: begin
          if (b == CH_GT) begin
            if (rec_count >= MAX_RECORDS_DEF) begin
              // Table full: flag it and leave everything else alone
              failed = 1'b1;
              emit(KIND_ERROR, '0, '0, '0, '0);
            end else begin
              pstate = PS_HEADER;
              seq_byte(CH_NUL);
              seq_ends[rec_count] = seq_fill;
              emit(KIND_START, CH_NUL, rec_count, hdr_fill, '0);
              rec_count = rec_count + 11'd1;
            end
          end else if (b == CH_SEMI) begin
            pstate = PS_COMMENT;
          end else if (printable) begin
            pstate = PS_SEQUENCE;
            seq_byte(b);
          end
        end
        PS_HEADER: begin
          if (b == CH_SEMI) begin
            pstate = PS_COMMENT;
            head_byte(CH_NUL);
          end else if (b == CH_NL) begin
            pstate = PS_NEWLINE;
            head_byte(CH_NUL);
          end else if (printable || b == CH_TAB) begin
            head_byte(b);
          end
        end
        default: begin
          if (b == CH_SEMI) pstate = PS_COMMENT;
          else if (b == CH_NL) pstate = PS_NEWLINE;
          else if (printable) seq_byte(b);
        end
      endcase
    endfunction

    // Binary search of the sequence ends for the first end above pos
    function void locate(logic [31:0] pos);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      logic [31:0] base;
      if (rec_count == 0 || pos >= seq_ends[rec_count - 11'd1]) begin
        emit(KIND_MISS, '0, '0, '0, '0);
        return;
      end
      lo = 0;
      hi = 32'(rec_count);
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (pos < seq_ends[mid]) hi = mid;
        else lo = mid + 1;
      end
      base = (lo == 0) ? 32'd0 : seq_ends[lo - 1];
      emit(KIND_HIT, '0, lo[10:0], '0, pos - base);
    endfunction

    function void note_item(in_item_t it);
      fresh.delete();
      case (it.mode)
        MODE_LOOKUP: locate(it.position);
        MODE_BYTE, MODE_EOF: begin
          if (failed) begin
            emit(KIND_ERROR, '0, '0, '0, '0);
          end else if (it.mode == MODE_BYTE) begin
            parse_byte(it.in_byte);
          end else begin
            // End of file closes the last sequence
            seq_byte(CH_NUL);
            pstate = PS_NEWLINE;
          end
        end
        default: ;
      endcase
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) owed.push_back(fresh[i]);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task match(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h want %0h", checked, name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        report($sformatf("result kind %0d arrived with none owed", got.kind));
        return;
      end
      want = owed.pop_front();
      match("kind", 32'(got.kind), 32'(want.kind));
      match("out_byte", 32'(got.out_byte), 32'(want.out_byte));
      match("record_index", 32'(got.record_index), 32'(want.record_index));
      match("store_position", got.store_position, want.store_position);
      match("local_offset", got.local_offset, want.local_offset);
      match("last", 32'(got.last), 32'(want.last));
      checked++;
    endtask
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  fasta_index_board board = new();
  int unsigned      sent_items = 0;
  int unsigned      tx_pct = 34;
  int unsigned      rx_pct = 62;

  fasta_record_indexer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < rx_pct);
  end

  // Check every result taken from the block
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) board.check_result(out_item);
  end

  // Offer one item, idling first at random, and note it once taken
  task automatic send(input logic [1:0] m, input logic [7:0] b, input logic [31:0] p);
    in_item_t it;
    int       gap;
    it.mode     = m;
    it.in_byte  = b;
    it.position = p;
    gap = 0;
    while (gap < 8 && $urandom_range(99) < tx_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
    board.note_item(it);
    if (m != MODE_NONE) sent_items++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    send(MODE_BYTE, b, $urandom());
  endtask

  task automatic put_eof();
    send(MODE_EOF, 8'($urandom_range(255)), $urandom());
  endtask

  task automatic put_lookup(input logic [31:0] p);
    send(MODE_LOOKUP, 8'($urandom_range(255)), p);
  endtask

  function automatic logic [7:0] pick_residue();
    logic [7:0] c;
    string      bases;
    bases = "ACGTN";
    if ($urandom_range(9) < 7) return bases[$urandom_range(4)];
    c = 8'($urandom_range(8'h7F, 8'h20));
    if (c == CH_GT || c == CH_SEMI) c = "N";
    return c;
  endfunction

  function automatic logic [7:0] pick_title_char();
    logic [7:0] c;
    if ($urandom_range(9) == 0) return CH_TAB;
    c = 8'($urandom_range(8'h7F, 8'h20));
    if (c == CH_SEMI) c = "_";
    return c;
  endfunction

  // Lookups aimed inside, at the edges of, and far beyond the table
  task automatic send_lookups(input int n);
    logic [31:0] p;
    repeat (n) begin
      case ($urandom_range(3))
        0: p = (board.seq_fill == 0) ? 32'd0 : $urandom_range(board.seq_fill - 1);
        1: p = board.seq_fill - $urandom_range(2);
        2: p = $urandom();
        default: p = (board.rec_count == 0) ? 32'd0 :
                     board.seq_ends[$urandom_range(board.rec_count - 1)];
      endcase
      put_lookup(p);
    end
  endtask

  // One well-formed record with random header, comments and sequence lines
  task automatic send_record();
    put_byte(CH_GT);
    repeat ($urandom_range(12)) put_byte(pick_title_char());
    if ($urandom_range(4) == 0) begin
      put_byte(CH_SEMI);
      repeat ($urandom_range(5)) put_byte(8'($urandom_range(255)));
    end
    put_byte(CH_NL);
    repeat ($urandom_range(3)) begin
      if ($urandom_range(7) == 0) begin
        put_byte(CH_SEMI);
        repeat ($urandom_range(4)) put_byte(pick_residue());
      end else begin
        repeat ($urandom_range(15, 1)) put_byte(pick_residue());
      end
      put_byte(CH_NL);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, stray bytes, comments, header edges, end of file
    put_lookup(32'd0);
    put_eof();
    send(MODE_NONE, 8'hFF, 32'hFFFF_FFFF);
    put_byte("A");
    put_byte(8'h80);
    put_byte(CH_NL);
    put_byte(CH_SEMI);
    put_byte(CH_GT);
    put_byte(CH_NL);
    put_byte(CH_GT);
    put_byte(CH_TAB);
    put_byte(CH_SPACE);
    put_byte(CH_DEL);
    put_byte(8'hFF);
    put_eof();
    put_byte(CH_GT);
    put_byte(CH_SEMI);
    put_byte(CH_NL);
    put_byte("G");
    put_byte(CH_NUL);
    put_byte(CH_NL);
    put_lookup(32'd0);
    put_lookup(board.seq_fill - 1);
    put_lookup(32'hFFFF_FFFF);
    put_eof();

    // Random: mostly well-formed records, with lookups, noise and stray ends
    while (sent_items < 420) begin
      if (sent_items >= 210) begin
        tx_pct = 62;
        rx_pct = 34;
      end
      case ($urandom_range(99)) inside
        [0:54]:  send_record();
        [55:74]: send_lookups($urandom_range(3, 1));
        [75:84]: put_eof();
        [85:94]: repeat ($urandom_range(4, 1)) put_byte(8'($urandom_range(255)));
        default: send(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom());
      endcase
    end

    // Records and lookups back to back with no idling
    tx_pct = 0;
    rx_pct = 0;
    put_byte(CH_NL);
    while (sent_items < 500) begin
      send_record();
      send_lookups(2);
    end
    put_eof();
    send_lookups(24);
    put_byte(CH_GT);
    in_valid <= 1'b0;

    // Drain, then allow for a search still in flight
    while (board.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("fasta_record_indexer verification clean");
    end else begin
      $display("fasta_record_indexer verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("fasta_record_indexer verification failed");
    $finish;
  end

endmodule

`default_nettype wire
